/* rtl/core/cfir_pkg.sv */
package cfir_pkg;

  // defaults for the top-level parameters
  localparam int DEF_TAPS       = 21;
  localparam int DEF_MAX_CH     = 8;
  localparam int TABLE_LEN      = 21;

  // register map
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

  localparam logic [15:0] MIX_ONE       = 16'd32768;
  localparam logic [15:0] MIX_RESET     = 16'd32768;
  localparam logic [3:0]  COUNT_RESET   = 4'd2;

  // datapath widths: blended coefficient stays below 2^27 in magnitude
  localparam int SMP_W   = 16;
  localparam int TBL_W   = 18;
  localparam int COEF_W  = 28;
  localparam int PROD_W  = COEF_W + SMP_W;
  localparam int ACC_W   = PROD_W + 6;
  localparam int FRAC_SH = 32;
  localparam int Q_W     = ACC_W - FRAC_SH;

  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(32767);
  localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(32768);

  typedef struct packed {
    logic clr_wr;    // clearing pass: write zero, step address
    logic load;      // take the input item
    logic wr_smp;    // write new sample into history
    logic issue;     // read one tap
    logic res_load;  // move result into output register
  } cfir_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass at final entry
    logic ch_ok;     // incoming channel has storage
    logic tap_last;  // issuing final tap
    logic pipe_busy; // MAC pipeline still holds taps
    logic out_free;  // output register can take a result
  } cfir_sts_t;

  function automatic logic signed [TBL_W-1:0] coef_one(input logic [4:0] idx);
    logic signed [TBL_W-1:0] c;
    case (idx)
      5'd0, 5'd20: c = -18'sd458;
      5'd1, 5'd19: c = 18'sd63;
      5'd2, 5'd18: c = 18'sd602;
      5'd3, 5'd17: c = 18'sd1142;
      5'd4, 5'd16: c = 18'sd1662;
      5'd5, 5'd15: c = 18'sd2143;
      5'd6, 5'd14: c = 18'sd2565;
      5'd7, 5'd13: c = 18'sd2912;
      5'd8, 5'd12: c = 18'sd3170;
      5'd9, 5'd11: c = 18'sd3329;
      5'd10:       c = 18'sd3383;
      default:     c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [TBL_W-1:0] coef_two(input logic [4:0] idx);
    logic signed [TBL_W-1:0] c;
    case (idx)
      5'd0, 5'd20: c = -18'sd2506;
      5'd1, 5'd19: c = -18'sd3311;
      5'd2, 5'd18: c = -18'sd3634;
      5'd3, 5'd17: c = -18'sd3402;
      5'd4, 5'd16: c = -18'sd2630;
      5'd5, 5'd15: c = -18'sd1425;
      5'd6, 5'd14: c = 18'sd32;
      5'd7, 5'd13: c = 18'sd1515;
      5'd8, 5'd12: c = 18'sd2786;
      5'd9, 5'd11: c = 18'sd3642;
      5'd10:       c = 18'sd3943;
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/crossfaded_fir_multichannel.sv */
// Multichannel FIR with coefficient crossfade.
//
// Input channel (in_valid/in_ready): one interleaved Q1.15 sample and its
// channel number per item. Output channel (out_valid/out_ready): one
// saturated Q1.15 filtered sample per input item, tagged with the channel.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 = mix (Q1.15, values
// above 1.0 act as 1.0), index 1 = channels per frame. Write only while idle.
//
// Each item is worked by one shared multiply-accumulate that walks the
// channel's history in a RAM with one write and one read port, one tap per
// cycle. The block takes a new item right after the result of the last one
// is loaded, so the tap walk plus the 3-stage MAC drain set the item rate.
//
// Reset: a clearing pass zeroes every history entry with in_ready low;
// config writes are taken meanwhile. A result waiting in the output
// register does not stop the next item from being accepted and filtered;
// only loading the next result waits for out_ready.
module crossfaded_fir_multichannel
  import cfir_pkg::*;
#(
  parameter int TAPS         = DEF_TAPS,
  parameter int MAX_CHANNELS = DEF_MAX_CH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  // sample in
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] in_sample,
  input  logic [2:0]              in_channel,
  // filtered out
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_filtered,
  output logic [2:0]              out_channel
);

  cfir_cmd_t cmd;
  cfir_sts_t sts;

  // sequencer: clear pass, accept, history write, tap walk, drain, result
  cfir_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // config regs, history RAM, blend + MAC pipeline, rounding, output reg
  cfir_dp #(
    .TAPS         (TAPS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_sample    (in_sample),
    .in_channel   (in_channel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .out_channel  (out_channel),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

/* rtl/core/cfir_ram.sv */
module cfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/cfir_ctrl.sv */
module cfir_ctrl
  import cfir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  cfir_sts_t sts,
  output cfir_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_TAPS,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          // channel without storage: straight to a zero result
          state_nxt = sts.ch_ok ? S_WRITE : S_DONE;
        end
      end
      S_WRITE: begin
        cmd.wr_smp = 1'b1;
        state_nxt  = S_TAPS;
      end
      S_TAPS: begin
        cmd.issue = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_ready_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pipe_busy)
    else $error("input taken while MAC pipeline busy");

  a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("second item taken right after load");

endmodule

/* rtl/core/cfir_dp.sv */
module cfir_dp
  import cfir_pkg::*;
#(
  parameter int TAPS         = DEF_TAPS,
  parameter int MAX_CHANNELS = DEF_MAX_CH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic signed [SMP_W-1:0] in_sample,
  input  logic [2:0]             in_channel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [SMP_W-1:0] out_filtered,
  output logic [2:0]             out_channel,
  input  cfir_cmd_t              cmd,
  output cfir_sts_t              sts
);

  localparam int DEPTH = MAX_CHANNELS * TAPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(TAPS);
  localparam int NT    = (TAPS < TABLE_LEN) ? TAPS : TABLE_LEN;
  localparam int TW    = $clog2(NT);
  localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-FRAC_SH){1'b0}}, 1'b1,
                                                  {(FRAC_SH-1){1'b0}}};

  // configuration
  logic [15:0] mix_r;
  logic [3:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r   <= MIX_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIX:   mix_r   <= cfg_wdata[15:0];
        CFG_COUNT: count_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  logic [15:0] mix_eff;
  logic [3:0]  count_eff;
  logic [3:0]  last_ch;

  always_comb begin
    mix_eff = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
    if (count_r == 4'd0) begin
      count_eff = 4'd1;
    end else if (32'(count_r) > MAX_CHANNELS) begin
      count_eff = 4'(MAX_CHANNELS);
    end else begin
      count_eff = count_r;
    end
    last_ch = count_eff - 4'd1;
  end

  // item and sequencing registers
  logic signed [SMP_W-1:0] sample_r;
  logic [2:0]              ch_r;
  logic                    ch_ok_r;
  logic [AW-1:0]           addr_r;
  logic [SW-1:0]           slot_r;
  logic [SW-1:0]           pos_r;
  logic [TW-1:0]           tap_r;
  logic                    in_ch_ok;
  logic [AW-1:0]           base_addr;

  assign in_ch_ok  = 32'(in_channel) < MAX_CHANNELS;
  assign base_addr = AW'(32'(in_channel) * TAPS) + AW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      pos_r  <= '0;
      tap_r  <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.load) begin
        addr_r <= base_addr;
        slot_r <= pos_r;
        tap_r  <= '0;
      end else if (cmd.clr_wr) begin
        addr_r <= addr_r + AW'(1);
      end else if (cmd.issue) begin
        tap_r <= tap_r + TW'(1);
        // walk back through the channel's ring
        if (slot_r == '0) begin
          slot_r <= SW'(TAPS - 1);
          addr_r <= addr_r + AW'(TAPS - 1);
        end else begin
          slot_r <= slot_r - SW'(1);
          addr_r <= addr_r - AW'(1);
        end
      end
      if (cmd.res_load && ch_ok_r && ({1'b0, ch_r} == last_ch)) begin
        pos_r <= (pos_r == SW'(TAPS - 1)) ? '0 : pos_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
      ch_r     <= in_channel;
      ch_ok_r  <= in_ch_ok;
    end
  end

  // history store
  logic [SMP_W-1:0] ram_rdata;

  cfir_ram #(
    .WIDTH (SMP_W),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.clr_wr | cmd.wr_smp),
    .waddr (addr_r),
    .wdata (cmd.clr_wr ? '0 : sample_r),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // coefficient blend: b1*32768 + (b2-b1)*mix
  logic signed [TBL_W-1:0]  t1, t2;
  logic signed [TBL_W:0]    dif;
  logic signed [36:0]       blend;

  always_comb begin
    t1    = coef_one(5'(tap_r));
    t2    = coef_two(5'(tap_r));
    dif   = (TBL_W+1)'(t2) - (TBL_W+1)'(t1);
    blend = (37'(dif) * 37'($signed({1'b0, mix_eff}))) + (37'(t1) <<< 15);
  end

  // MAC pipeline: coef/history -> product -> accumulate
  logic                     v1_r, v2_r;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= COEF_W'(blend);
    prod_r <= PROD_W'(coef_r) * PROD_W'($signed(ram_rdata));
    if (cmd.load) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then saturate
  logic signed [ACC_W-1:0] rnd;
  logic signed [Q_W-1:0]   q;
  logic signed [SMP_W-1:0] sat;

  always_comb begin
    rnd = acc_r + RND_HALF;
    q   = $signed(rnd[ACC_W-1:FRAC_SH]);
    if (q > SAT_HI) begin
      sat = 16'sh7FFF;
    end else if (q < SAT_LO) begin
      sat = -16'sh8000;
    end else begin
      sat = q[SMP_W-1:0];
    end
  end

  // output register
  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_filtered_r;
  logic [2:0]              out_channel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_filtered_r <= sat;
      out_channel_r  <= ch_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_channel  = out_channel_r;

  assign sts.clr_last  = (addr_r == AW'(DEPTH - 1));
  assign sts.ch_ok     = in_ch_ok;
  assign sts.tap_last  = (tap_r == TW'(NT - 1));
  assign sts.pipe_busy = v1_r | v2_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote an untaken item");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("product stage valid without coefficient stage");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pos_r) < TAPS)
    else $error("frame position out of range");

endmodule
